// File: src/acs_pkg.sv
package acs_pkg;

  // Claim phases, encoded as on the phase output field
  typedef enum logic [2:0] {
    PH_INIT     = 3'd0,
    PH_AGAIN    = 3'd1,
    PH_START    = 3'd2,
    PH_PENDING  = 3'd3,
    PH_FINISHED = 3'd4,
    PH_OPER     = 3'd5,
    PH_FAILED   = 3'd6
  } claim_phase_t;

  // Item operation codes
  localparam logic OP_POLL    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLAIM_TIMEOUT_MS = 8'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values and arithmetic constants
  localparam logic [7:0]  START_ADDRESS_RST = 8'd128;
  localparam logic [15:0] CLAIM_TIMEOUT_RST = 16'd250;
  localparam logic [7:0]  WAIT_RST          = 8'd153;
  localparam logic [7:0]  WAIT_BASE         = 8'd10;
  localparam logic [15:0] WAIT_SPAN         = 16'd153;
  // floor(2^17 / 153), quotient estimate is low by at most one
  localparam logic [9:0]  WAIT_RECIP        = 10'd856;
  localparam int unsigned WAIT_RECIP_SHIFT  = 17;
  localparam logic [8:0]  ADDR_COUNT        = 9'd254;

  typedef struct packed {
    logic        op;
    logic        lost_seen;
    logic [31:0] now_ms;
    logic [14:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic       operational;
    logic [2:0] phase;
    logic [7:0] own_address;
    logic       send_claim;
    logic       send_cannot_claim;
    logic       send_request_claims;
  } out_item_t;

  // Sequencer state carried from item to item
  typedef struct packed {
    claim_phase_t phase;
    logic         lost;
    logic [7:0]   addr;
    logic [31:0]  start_time;
    logic [7:0]   wait_ms;
  } claim_state_t;

endpackage

// File: src/acs_step.sv
module acs_step import acs_pkg::*; (
  input  claim_state_t st,
  input  in_item_t     item,
  input  logic [7:0]   start_address,
  input  logic [15:0]  claim_timeout_ms,
  output claim_state_t st_nxt,
  output out_item_t    result
);

  logic         lost_or;
  logic [24:0]  recip_prod;
  logic [7:0]   quot_est;
  logic [15:0]  quot_mul;
  logic [15:0]  rem_raw;
  logic [15:0]  rem;
  logic [7:0]   wait_new;
  logic [31:0]  since;
  logic         wait_done;
  logic         timeout_done;
  logic [8:0]   addr_plus;
  logic [7:0]   addr_inc;
  logic         wrap_home;
  claim_phase_t phase_nxt;
  logic         s_claim;
  logic         s_cannot;
  logic         s_req;

  assign lost_or = st.lost | item.lost_seen;

  // Back-off: 10 + random_value mod 153 by reciprocal multiply and one correction
  assign recip_prod = 25'(item.random_value) * 25'(WAIT_RECIP);
  assign quot_est   = recip_prod[24:WAIT_RECIP_SHIFT];
  assign quot_mul   = 16'(quot_est) * WAIT_SPAN;
  assign rem_raw    = 16'(item.random_value) - quot_mul;
  assign rem        = (rem_raw >= WAIT_SPAN) ? (rem_raw - WAIT_SPAN) : rem_raw;
  assign wait_new   = rem[7:0] + WAIT_BASE;

  // Elapsed tests on wrapping millisecond time
  assign since        = item.now_ms - st.start_time;
  assign wait_done    = since >= 32'(st.wait_ms);
  assign timeout_done = since >= 32'(claim_timeout_ms);

  // Next address modulo 254; a single subtract covers inputs up to 255
  assign addr_plus = 9'(st.addr) + 9'd1;
  assign addr_inc  = (addr_plus >= ADDR_COUNT) ? 8'(addr_plus - ADDR_COUNT) : addr_plus[7:0];
  assign wrap_home = addr_inc == start_address;

  // Next phase
  always_comb begin
    phase_nxt = st.phase;
    if (item.op == OP_RESTART) begin
      phase_nxt = PH_INIT;
    end else begin
      case (st.phase)
        PH_INIT, PH_AGAIN: begin
          phase_nxt = PH_START;
        end
        PH_START: begin
          if (lost_or || wait_done) phase_nxt = PH_PENDING;
        end
        PH_PENDING: begin
          if (lost_or) phase_nxt = wrap_home ? PH_FAILED : PH_AGAIN;
          else if (timeout_done) phase_nxt = PH_FINISHED;
        end
        PH_FINISHED: begin
          if (lost_or) phase_nxt = wrap_home ? PH_FAILED : PH_AGAIN;
          else phase_nxt = PH_OPER;
        end
        PH_OPER: begin
          if (lost_or) phase_nxt = wrap_home ? PH_FAILED : PH_AGAIN;
        end
        default: begin
          phase_nxt = st.phase;
        end
      endcase
    end
  end

  // Data state and frame requests
  always_comb begin
    st_nxt       = st;
    st_nxt.phase = phase_nxt;
    s_claim      = 1'b0;
    s_cannot     = 1'b0;
    s_req        = 1'b0;
    if (item.op == OP_RESTART) begin
      st_nxt.addr = start_address;
      st_nxt.lost = 1'b0;
    end else begin
      st_nxt.lost = lost_or;
      case (st.phase)
        PH_INIT, PH_AGAIN: begin
          st_nxt.lost       = 1'b0;
          st_nxt.start_time = item.now_ms;
          st_nxt.wait_ms    = wait_new;
        end
        PH_START: begin
          s_claim = !lost_or && wait_done;
        end
        PH_PENDING, PH_FINISHED, PH_OPER: begin
          if (lost_or) begin
            st_nxt.lost = 1'b0;
            st_nxt.addr = addr_inc;
            s_cannot    = wrap_home;
          end else if (st.phase == PH_FINISHED) begin
            s_req = 1'b1;
          end
        end
        default: begin
          s_claim = 1'b0;
        end
      endcase
    end
  end

  // Pack the result item
  always_comb begin
    result.operational         = phase_nxt == PH_OPER;
    result.phase               = phase_nxt;
    result.own_address         = st_nxt.addr;
    result.send_claim          = s_claim;
    result.send_cannot_claim   = s_cannot;
    result.send_request_claims = s_req;
  end

endmodule

// File: src/address_claim_sequencer.sv
// Address-claim sequencer: each item is one poll (or a restart) and yields exactly one result
// item giving the phase, own address and the frame requests for that step. An accepted item
// lands in an input register and its result is captured in the output register when that
// register is free or being drained, so one item is taken every cycle while the result side
// keeps up; the single-pass step logic between the two registers also updates the claim
// state. Configuration writes (index 0 start address, index 1 claim timeout in ms) are always
// ready and must be issued only while no item is in flight.
module address_claim_sequencer import acs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic         in_vld_r;
  logic         in_vld_nxt;
  in_item_t     in_item_r;
  logic         out_vld_r;
  logic         out_vld_nxt;
  out_item_t    out_item_r;
  claim_state_t st_r;
  claim_state_t st_nxt;
  out_item_t    step_result;
  logic [7:0]   start_address_r;
  logic [15:0]  claim_timeout_r;
  logic         advance;
  logic         in_accept;

  // Handshake control
  assign advance     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = in_vld_r && !advance;
  assign in_accept   = in_valid && !in_stall;
  assign in_vld_nxt  = in_accept || (in_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && out_stall);
  assign out_valid   = out_vld_r;
  assign out_data    = out_item_r;
  assign cfg_ready   = 1'b1;

  acs_step u_step (
    .st               (st_r),
    .item             (in_item_r),
    .start_address    (start_address_r),
    .claim_timeout_ms (claim_timeout_r),
    .st_nxt           (st_nxt),
    .result           (step_result)
  );

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture the input item and the result item
  always_ff @(posedge clk) begin
    if (in_accept) in_item_r <= in_data;
    if (advance) out_item_r <= step_result;
  end

  // Advance the claim state once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_INIT;
      st_r.lost       <= 1'b0;
      st_r.addr       <= START_ADDRESS_RST;
      st_r.start_time <= '0;
      st_r.wait_ms    <= WAIT_RST;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_address_r <= START_ADDRESS_RST;
      claim_timeout_r <= CLAIM_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_ADDRESS:    start_address_r <= cfg_data[7:0];
        REG_CLAIM_TIMEOUT_MS: claim_timeout_r <= cfg_data;
        default:              start_address_r <= start_address_r;
      endcase
    end
  end

  // A cannot-claim request only comes with the failed phase
  a_cannot_failed: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.send_cannot_claim |-> out_item_r.phase == PH_FAILED)
    else $error("cannot-claim request outside failed phase");

  // Operational flag tracks the reported phase
  a_oper_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_item_r.operational == (out_item_r.phase == PH_OPER))
    else $error("operational flag disagrees with phase");

  // Request of claims only leaves the finished phase
  a_req_from_finished: assert property (@(posedge clk) disable iff (!rst_n)
    advance && step_result.send_request_claims |-> st_r.phase == PH_FINISHED)
    else $error("request of claims outside finished phase");

  // A restart reloads the start address
  a_restart_addr: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_item_r.op == OP_RESTART |=> st_r.addr == start_address_r)
    else $error("restart did not load start address");

endmodule
